@@ sv/udds_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// udds_pkg
// Beat types and fixed codes for the up/down digital potentiometer stepper.
// ----------------------------------------------------------------------------
package udds_pkg;

    localparam int PCT_W     = 7;
    localparam int POS_OUT_W = 7;
    localparam int PCT_MAX   = 100;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [PCT_W-1:0] set_percent;
        logic             reset_request;
    } udds_in_t;

    typedef struct packed {
        logic                 step_clock;
        logic                 up_direction;
        logic [POS_OUT_W-1:0] position;
        logic                 position_valid;
        logic [POS_OUT_W-1:0] target_position;
        logic                 busy_res;
        logic                 rejected;
    } udds_out_t;

endpackage
`default_nettype wire

@@ sv/updown_digipot_stepper.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// updown_digipot_stepper
// Step clock and direction driver for an up/down-clocked digital potentiometer.
//
// s_valid/s_ready/s_data carry command beats: a timer tick (opcode tick) or a
// set of a new target percent, optionally with a homing request. Each input
// beat yields exactly one result beat on m_valid/m_ready/m_data with the step
// clock level, direction, tracked wiper position, target and busy flag after
// that beat; a percent above 100 returns rejected with no state change.
// The result beat passes the input register, then the state update into the
// result register, before it is valid; a stall can hold it in either. One
// beat is taken every cycle while the receiver does not stall; the rate is set
// by the state update loop.
// Reset (aresetn low, synchronous) leaves the driver idle, clock high,
// direction up, position unknown and target at the top position.
// When the receiver stalls, the result register holds its beat, the state is
// frozen, and s_ready drops as soon as the input register also holds a beat.
// ----------------------------------------------------------------------------
module updown_digipot_stepper #(
    parameter int NUM_POSITIONS = 128,
    parameter int HOMING_EXTRA  = 10
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire udds_pkg::udds_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output udds_pkg::udds_out_t      m_data
);
    import udds_pkg::*;

    logic     q_valid;
    logic     q_ready;
    udds_in_t q_data;

    udds_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    udds_core #(
        .NUM_POSITIONS (NUM_POSITIONS),
        .HOMING_EXTRA  (HOMING_EXTRA)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_data  (q_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

@@ sv/udds_in_reg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// udds_in_reg
// Input register stage: holds one command beat for the stepper core.
// ----------------------------------------------------------------------------
module udds_in_reg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire udds_pkg::udds_in_t s_data,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output udds_pkg::udds_in_t      q_data
);
    import udds_pkg::*;

    logic     valid_reg;
    udds_in_t data_reg;

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= s_data;
        end
    end

endmodule
`default_nettype wire

@@ sv/udds_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// udds_core
// Stepper state update and result register: one command or tick per beat.
// ----------------------------------------------------------------------------
module udds_core #(
    parameter int NUM_POSITIONS = 128,
    parameter int HOMING_EXTRA  = 10
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire udds_pkg::udds_in_t in_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output udds_pkg::udds_out_t     m_data
);
    import udds_pkg::*;

    localparam int POS_W   = $clog2(NUM_POSITIONS);
    localparam int HOME_W  = $clog2(NUM_POSITIONS + HOMING_EXTRA + 1);
    localparam int LUT_N   = 2 ** PCT_W;

    localparam logic [POS_W-1:0]  POS_TOP    = POS_W'(NUM_POSITIONS - 1);
    localparam logic [HOME_W-1:0] HOME_TOTAL = HOME_W'(NUM_POSITIONS + HOMING_EXTRA);
    localparam logic [PCT_W-1:0]  PCT_LIMIT  = PCT_W'(PCT_MAX);

    typedef logic [POS_W-1:0] lut_t [0:LUT_N-1];

    function automatic lut_t build_lut();
        lut_t t;
        for (int i = 0; i < LUT_N; i++) begin
            if (i <= PCT_MAX) begin
                t[i] = POS_W'((i * (NUM_POSITIONS - 1)) / PCT_MAX);
            end else begin
                t[i] = '0;
            end
        end
        return t;
    endfunction

    localparam lut_t TARGET_LUT = build_lut();

    logic              clk_level_reg, clk_level_next;
    logic              dir_up_reg, dir_up_next;
    logic [POS_W-1:0]  wiper_pos_reg, wiper_pos_next;
    logic              wiper_known_reg, wiper_known_next;
    logic [POS_W-1:0]  target_reg, target_next;
    logic [HOME_W-1:0] home_cnt_reg, home_cnt_next;
    logic              running_reg, running_next;
    logic              rej;
    logic              fire;
    logic              out_valid_reg;
    udds_out_t         out_reg, out_next;
    logic [POS_W+POS_OUT_W-1:0] pos_ext, tgt_ext;

    assign in_ready = !out_valid_reg || m_ready;
    assign fire     = in_valid && in_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        clk_level_next   = clk_level_reg;
        dir_up_next      = dir_up_reg;
        wiper_pos_next   = wiper_pos_reg;
        wiper_known_next = wiper_known_reg;
        target_next      = target_reg;
        home_cnt_next    = home_cnt_reg;
        running_next     = running_reg;
        rej              = 1'b0;
        if (in_data.opcode == OP_SET) begin
            if (in_data.set_percent > PCT_LIMIT) begin
                rej = 1'b1;
            end else begin
                target_next = TARGET_LUT[in_data.set_percent];
                if ((home_cnt_reg != '0) || in_data.reset_request || !wiper_known_reg) begin
                    home_cnt_next    = HOME_TOTAL;
                    dir_up_next      = 1'b1;
                    wiper_known_next = 1'b0;
                    wiper_pos_next   = '0;
                end
                running_next = 1'b1;
            end
        end else if (running_reg) begin
            if (!clk_level_reg) begin
                clk_level_next = 1'b1;
                if ((home_cnt_reg == '0) && wiper_known_reg && (wiper_pos_reg == target_reg)) begin
                    running_next = 1'b0;
                end
            end else if (home_cnt_reg != '0) begin
                home_cnt_next  = home_cnt_reg - 1'b1;
                clk_level_next = 1'b0;
                if (home_cnt_reg == HOME_W'(1)) begin
                    wiper_pos_next   = POS_TOP;
                    wiper_known_next = 1'b1;
                end
            end else if (wiper_pos_reg < target_reg) begin
                dir_up_next    = 1'b1;
                wiper_pos_next = wiper_pos_reg + 1'b1;
                clk_level_next = 1'b0;
            end else if (wiper_pos_reg > target_reg) begin
                dir_up_next    = 1'b0;
                wiper_pos_next = wiper_pos_reg - 1'b1;
                clk_level_next = 1'b0;
            end
        end
    end

    always_comb begin
        pos_ext = {{POS_OUT_W{1'b0}}, wiper_pos_next};
        tgt_ext = {{POS_OUT_W{1'b0}}, target_next};
        out_next.step_clock      = clk_level_next;
        out_next.up_direction    = dir_up_next;
        out_next.position        = wiper_known_next ? pos_ext[POS_OUT_W-1:0] : '0;
        out_next.position_valid  = wiper_known_next;
        out_next.target_position = tgt_ext[POS_OUT_W-1:0];
        out_next.busy_res        = running_next;
        out_next.rejected        = rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_level_reg   <= 1'b1;
            dir_up_reg      <= 1'b1;
            wiper_pos_reg   <= '0;
            wiper_known_reg <= 1'b0;
            target_reg      <= POS_TOP;
            home_cnt_reg    <= '0;
            running_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (fire) begin
                clk_level_reg   <= clk_level_next;
                dir_up_reg      <= dir_up_next;
                wiper_pos_reg   <= wiper_pos_next;
                wiper_known_reg <= wiper_known_next;
                target_reg      <= target_next;
                home_cnt_reg    <= home_cnt_next;
                running_reg     <= running_next;
            end
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= out_next;
        end
    end

    a_known_not_homing: assert property (@(posedge aclk) disable iff (!aresetn)
        wiper_known_reg |-> (home_cnt_reg == '0))
        else $error("wiper known during homing run");

    a_idle_clock_high: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> clk_level_reg)
        else $error("step clock low while idle");

    a_home_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        home_cnt_reg <= HOME_TOTAL)
        else $error("homing count out of range");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=>
            ($stable(wiper_pos_reg) && $stable(home_cnt_reg) && $stable(running_reg)))
        else $error("state advanced while result stalled");

    a_unknown_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !wiper_known_reg |-> (wiper_pos_reg == '0))
        else $error("position nonzero while unknown");

endmodule
`default_nettype wire

@@ test/updown_digipot_stepper_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// updown_digipot_stepper_tb
// Self-checking bench for the up/down digital potentiometer stepper.
//
// Command beats (ticks, set commands with and without homing, out-of-range
// percents) go in on the s_ channel. A scoreboard class keeps its own copy of
// the driver state, predicts the result beat for every accepted command and
// checks each m_ beat, field by field, in order. Both sides idle in random
// bursts. One long result stall backs the block up, and the sender then waits
// for every pending result before it goes on.
// ----------------------------------------------------------------------------

import udds_pkg::*;

class digipot_scoreboard;
    localparam int NUM_POS    = 128;
    localparam int HOME_EXTRA = 10;

    bit        clock_level;
    bit        direction_up;
    bit        wiper_known;
    bit        running;
    bit [6:0]  wiper_position;
    bit [6:0]  target;
    bit [7:0]  homing_left;
    udds_out_t expected_beats[$];
    int        mismatches;

    function new();
        clock_level    = 1'b1;
        direction_up   = 1'b1;
        wiper_known    = 1'b0;
        running        = 1'b0;
        wiper_position = '0;
        target         = 7'(NUM_POS - 1);
        homing_left    = '0;
        mismatches     = 0;
    endfunction

    function int pending();
        return expected_beats.size();
    endfunction

    // idle, or parked high at target where further ticks change nothing
    function bit settled();
        return !running || (clock_level && homing_left == 0 && wiper_known
                            && wiper_position == target);
    endfunction

    function void note_command(udds_in_t cmd);
        udds_out_t want;
        bit        refused;
        refused = 1'b0;
        if (cmd.opcode == OP_SET) begin
            if (int'(cmd.set_percent) > PCT_MAX) begin
                refused = 1'b1;
            end else begin
                target = 7'((int'(cmd.set_percent) * (NUM_POS - 1)) / PCT_MAX);
                if (homing_left != 0 || cmd.reset_request || !wiper_known) begin
                    homing_left    = 8'(NUM_POS + HOME_EXTRA);
                    direction_up   = 1'b1;
                    wiper_known    = 1'b0;
                    wiper_position = '0;
                end
                running = 1'b1;
            end
        end else if (running) begin
            if (!clock_level) begin
                clock_level = 1'b1;
                if (homing_left == 0 && wiper_known && wiper_position == target)
                    running = 1'b0;
            end else if (homing_left != 0) begin
                homing_left--;
                if (homing_left == 0) begin
                    wiper_position = 7'(NUM_POS - 1);
                    wiper_known    = 1'b1;
                end
                clock_level = 1'b0;
            end else if (wiper_position < target) begin
                direction_up = 1'b1;
                wiper_position++;
                clock_level = 1'b0;
            end else if (wiper_position > target) begin
                direction_up = 1'b0;
                wiper_position--;
                clock_level = 1'b0;
            end
        end
        want.step_clock      = clock_level;
        want.up_direction    = direction_up;
        want.position        = wiper_known ? wiper_position : '0;
        want.position_valid  = wiper_known;
        want.target_position = target;
        want.busy_res        = running;
        want.rejected        = refused;
        expected_beats.push_back(want);
    endfunction

    function void field_check(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function void check_beat(udds_out_t got);
        udds_out_t want;
        if (expected_beats.size() == 0) begin
            $display("%0t: result beat with none expected, actual %h", $time, got);
            mismatches++;
            return;
        end
        want = expected_beats.pop_front();
        if ($isunknown(got)) begin
            $display("%0t: unknown bits in result, expected %h, actual %h",
                     $time, want, got);
            mismatches++;
            return;
        end
        field_check("step_clock", want.step_clock, got.step_clock);
        field_check("up_direction", want.up_direction, got.up_direction);
        field_check("position", want.position, got.position);
        field_check("position_valid", want.position_valid, got.position_valid);
        field_check("target_position", want.target_position, got.target_position);
        field_check("busy_res", want.busy_res, got.busy_res);
        field_check("rejected", want.rejected, got.rejected);
    endfunction
endclass

module updown_digipot_stepper_tb;

    localparam int ITEMS_TOTAL = 1350;
    localparam int QUIET_ITEMS = 150;
    localparam int LONG_HOLD   = 60;
    localparam int NUM_POS     = 128;
    localparam int HOME_EXTRA  = 10;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    udds_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    udds_out_t m_data;

    digipot_scoreboard sb;
    int  items_sent;
    bit  quiet_phase;
    bit  long_hold_req;
    bit  started;

    updown_digipot_stepper #(
        .NUM_POSITIONS(NUM_POS),
        .HOMING_EXTRA (HOME_EXTRA)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("updown_digipot_stepper regression: fail");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_beat(m_data);
    end

    // result side: random stalls, one long hold on request, none at the end
    initial begin
        wait (started);
        forever begin
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
    end

    // call at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input udds_in_t beat, input bit may_idle = 1'b1);
        if (may_idle && !quiet_phase && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_data  <= beat;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_command(beat);
        items_sent++;
        if (items_sent >= ITEMS_TOTAL - QUIET_ITEMS)
            quiet_phase = 1'b1;
        @(negedge aclk);
    endtask

    task automatic send_tick(input bit may_idle = 1'b1);
        udds_in_t beat;
        beat               = '0;
        beat.opcode        = OP_TICK;
        beat.set_percent   = 7'($urandom_range(0, 127));
        beat.reset_request = 1'($urandom_range(0, 1));
        send_beat(beat, may_idle);
    endtask

    task automatic send_set(input int pct, input bit home);
        udds_in_t beat;
        beat.opcode        = OP_SET;
        beat.set_percent   = 7'(pct);
        beat.reset_request = home;
        send_beat(beat);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // set a target, then tick until the driver rests there
    task automatic run_to_target(input int pct, input bit home);
        send_set(pct, home);
        while (!sb.settled() && items_sent < ITEMS_TOTAL) send_tick();
        repeat ($urandom_range(0, 2)) send_tick();
    endtask

    initial begin
        int last_pct;
        int kind;
        int pct;
        bit pressure_done;
        sb            = new();
        items_sent    = 0;
        quiet_phase   = 1'b0;
        long_hold_req = 1'b0;
        started       = 1'b0;
        pressure_done = 1'b0;
        last_pct      = 50;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        started = 1'b1;
        @(negedge aclk);

        send_tick();
        send_tick();
        send_set(101, 1'b0);
        send_set(127, 1'b1);
        send_set(0, 1'b0);
        repeat (4) send_tick();
        send_set(100, 1'b1);
        repeat (3) send_tick();
        send_set(50, 1'b0);
        repeat (5) send_tick();
        send_set(120, 1'b1);
        send_set(0, 1'b1);
        repeat (3) send_tick();
        wait_drained();

        while (items_sent < ITEMS_TOTAL) begin
            if (!pressure_done && items_sent >= ITEMS_TOTAL / 2) begin
                pressure_done = 1'b1;
                long_hold_req = 1'b1;
                repeat (24) send_tick(1'b0);
                wait_drained();
            end
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                case ($urandom_range(0, 9))
                    0:       pct = 0;
                    1:       pct = PCT_MAX;
                    2:       pct = last_pct;
                    default: pct = $urandom_range(0, PCT_MAX);
                endcase
                last_pct = pct;
                run_to_target(pct, $urandom_range(0, 7) == 0);
            end else if (kind <= 7) begin
                send_set($urandom_range(0, PCT_MAX), $urandom_range(0, 3) == 0);
                repeat ($urandom_range(0, 40)) send_tick();
            end else begin
                repeat ($urandom_range(4, 12)) begin
                    if ($urandom_range(0, 2) == 0)
                        send_set($urandom_range(0, 127), 1'($urandom_range(0, 1)));
                    else
                        send_tick();
                end
            end
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("updown_digipot_stepper regression: pass");
        else
            $display("updown_digipot_stepper regression: fail");
        $finish;
    end

endmodule
